/* sv/aleg_pkg.sv */
// Shared types, constants and index helper for the associated Legendre table.
package aleg_pkg;

  localparam int unsigned MaxOrder = 7;
  localparam int unsigned DivSteps = 7;

  localparam logic [47:0] OneQ29  = 48'h0000_2000_0000;
  localparam logic [47:0] SatHi   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SatLo   = 48'h8000_0000_0000;
  localparam logic [79:0] RoundQ30 = 80'h0000_0000_0000_2000_0000;

  typedef struct packed {
    logic signed [31:0] cos_value;
    logic signed [31:0] sin_value;
  } in_t;

  typedef struct packed {
    logic signed [47:0] coefficient;
    logic [5:0]         coeff_index;
    logic               last;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load_in;
    logic       re;
    logic [5:0] raddr;
    logic       we;
    logic [5:0] waddr;
    logic       wr_one;
    logic       cap_p1;
    logic       mul_lo;
    logic       mul_hi;
    logic       scale;
    logic       comb;
    logic       dinit;
    logic       dstep;
    logic       use_sin;
    logic       negate;
    logic [3:0] f;
    logic [3:0] g;
    logic [2:0] d;
    logic       out_load;
    logic [5:0] out_index;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Table position n*(n+1)+m.
  function automatic logic [5:0] idx_f(input logic [2:0] n, input logic [2:0] m);
    logic [5:0] nn;
    nn = {3'b000, n};
    return nn * (nn + 6'd1) + {3'b000, m};
  endfunction

endpackage

/* sv/aleg_dp.sv */
// Datapath: coefficient memory, split multiplier, scaling, radix-256 divider, output register.
module aleg_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aleg_pkg::cmd_t   cmd_i,
  output aleg_pkg::status_t status_o,
  input  aleg_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output aleg_pkg::out_t   out_data_o
);

  logic [47:0] coeff_mem_q [64];
  logic [47:0] rdata_q;
  logic [47:0] wdata;

  logic signed [31:0] cos_q, sin_q;
  logic signed [47:0] p1_q, p2_q;
  logic signed [79:0] acc_q;
  logic signed [54:0] t_q;
  logic signed [55:0] num_q;
  logic [55:0]        div_q;
  logic [3:0]         rem_q;
  logic               sign_q;

  logic signed [31:0] mul_b;
  logic signed [56:0] prod_lo;
  logic signed [55:0] prod_hi;
  logic signed [49:0] q_w;
  logic signed [52:0] gp;
  logic [55:0]        mag;
  logic [3:0]         dv;
  logic [55:0]        sh;
  logic [3:0]         r;
  logic [4:0]         rt;
  logic [47:0]        res_sat;

  aleg_pkg::out_t out_q;
  logic           out_valid_q;

  assign mul_b   = cmd_i.use_sin ? sin_q : cos_q;
  assign prod_lo = $signed({1'b0, p1_q[23:0]}) * mul_b;
  assign prod_hi = $signed(p1_q[47:24]) * mul_b;
  assign q_w     = acc_q[79:30];
  assign gp      = p2_q * $signed({1'b0, cmd_i.g});
  assign mag     = num_q[55] ? 56'(-num_q) : 56'(num_q);
  assign dv      = {cmd_i.d, 1'b0};

  // Eight quotient bits per cycle; remainder stays below 2d.
  always_comb begin
    sh = div_q;
    r  = rem_q;
    rt = '0;
    for (int i = 0; i < 8; i++) begin
      rt = {r, sh[55]};
      sh = {sh[54:0], 1'b0};
      if (rt >= {1'b0, dv}) begin
        rt    = rt - {1'b0, dv};
        sh[0] = 1'b1;
      end
      r = rt[3:0];
    end
  end

  always_comb begin
    if (!sign_q) begin
      res_sat = (|div_q[55:47]) ? aleg_pkg::SatHi : div_q[47:0];
    end else begin
      res_sat = (div_q > 56'h00_8000_0000_0000) ? aleg_pkg::SatLo : 48'(-div_q[47:0]);
    end
  end

  assign wdata = cmd_i.wr_one ? aleg_pkg::OneQ29 : res_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) coeff_mem_q[cmd_i.waddr] <= wdata;
    if (cmd_i.re) rdata_q <= coeff_mem_q[cmd_i.raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cos_q <= in_data_i.cos_value;
      sin_q <= in_data_i.sin_value;
    end
    if (cmd_i.cap_p1) p1_q <= rdata_q;
    if (cmd_i.mul_lo) begin
      p2_q  <= rdata_q;
      acc_q <= {{23{prod_lo[56]}}, prod_lo};
    end
    if (cmd_i.mul_hi) begin
      acc_q <= acc_q + ({{24{prod_hi[55]}}, prod_hi} << 24) + aleg_pkg::RoundQ30;
    end
    if (cmd_i.scale) t_q <= q_w * $signed({1'b0, cmd_i.f});
    if (cmd_i.comb) begin
      num_q <= (cmd_i.negate ? -{t_q[54], t_q} : {t_q[54], t_q}) - {{3{gp[52]}}, gp};
    end
    if (cmd_i.dinit) begin
      sign_q <= num_q[55];
      div_q  <= {mag[54:0], 1'b0} + {53'b0, cmd_i.d};
      rem_q  <= '0;
    end
    if (cmd_i.dstep) begin
      div_q <= sh;
      rem_q <= r;
    end
    if (cmd_i.out_load) begin
      out_q.coefficient <= rdata_q;
      out_q.coeff_index <= cmd_i.out_index;
      out_q.last        <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

/* sv/aleg_ctrl.sv */
// Controller: sequences seeding, recurrence entries, division steps and output reads.
module aleg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_data_i,
  input  aleg_pkg::status_t status_i,
  output aleg_pkg::cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_SEED  = 12'b0000_0000_0010,
    S_RD1   = 12'b0000_0000_0100,
    S_RD2   = 12'b0000_0000_1000,
    S_MUL1  = 12'b0000_0001_0000,
    S_MUL2  = 12'b0000_0010_0000,
    S_SCALE = 12'b0000_0100_0000,
    S_COMB  = 12'b0000_1000_0000,
    S_DINIT = 12'b0001_0000_0000,
    S_DIV   = 12'b0010_0000_0000,
    S_WR    = 12'b0100_0000_0000,
    S_ORD   = 12'b1000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic       oload_q, oload_d;   // output load cycle follows a read
  logic [2:0] order_q;
  logic [2:0] lim_q, lim_d;
  logic       phase_q, phase_d;   // 0: diagonal pair, 1: three-term recurrence
  logic       sub_q, sub_d;
  logic [2:0] n_q, n_d;
  logic [2:0] m_q, m_d;
  logic [2:0] cnt_q, cnt_d;
  logic [5:0] k_q, k_d;
  logic [2:0] on_q, on_d;
  logic signed [3:0] om_q, om_d;

  logic       accept;
  logic       is_last;
  logic [2:0] om_abs;
  logic [2:0] nm1;
  logic [2:0] tm;

  assign accept  = state_q == S_IDLE && !oload_q && in_valid_i;
  assign nm1     = n_q - 3'd1;
  assign tm      = phase_q ? m_q : (sub_q ? nm1 : n_q);
  assign om_abs  = om_q[3] ? 3'(-om_q) : om_q[2:0];
  assign is_last = on_q == lim_q && om_q == $signed({1'b0, lim_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 3'd1;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    oload_d = 1'b0;
    lim_d   = lim_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    n_d     = n_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    on_d    = on_q;
    om_d    = om_q;
    cmd_o   = '0;

    cmd_o.use_sin = !phase_q && !sub_q;
    cmd_o.negate  = !phase_q && !sub_q;
    cmd_o.f       = {n_q, 1'b0} - 4'd1;
    cmd_o.g       = phase_q ? ({1'b0, n_q} + {1'b0, m_q} - 4'd1) : 4'd0;
    cmd_o.d       = phase_q ? (n_q - m_q) : 3'd1;
    cmd_o.waddr   = aleg_pkg::idx_f(n_q, tm);
    cmd_o.out_index = k_q;
    cmd_o.out_last  = is_last;

    if (oload_q) begin
      // Read data waits in the memory register until the output register frees.
      if (status_i.out_free) begin
        cmd_o.out_load = 1'b1;
        if (is_last) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 6'd1;
          if (om_q == $signed({1'b0, on_q})) begin
            on_d = on_q + 3'd1;
            om_d = -$signed({1'b0, on_q + 3'd1});
          end else begin
            om_d = om_q + 4'sd1;
          end
          state_d = S_ORD;
        end
      end else begin
        oload_d = 1'b1;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.load_in = 1'b1;
            lim_d   = (32'(order_q) > aleg_pkg::MaxOrder) ?
                      3'(aleg_pkg::MaxOrder) : order_q;
            state_d = S_SEED;
          end
        end
        S_SEED: begin
          cmd_o.we     = 1'b1;
          cmd_o.waddr  = 6'd0;
          cmd_o.wr_one = 1'b1;
          phase_d = 1'b0;
          sub_d   = 1'b0;
          n_d     = 3'd1;
          k_d     = '0;
          on_d    = '0;
          om_d    = '0;
          state_d = (lim_q == 3'd0) ? S_ORD : S_RD1;
        end
        S_RD1: begin
          cmd_o.re    = 1'b1;
          cmd_o.raddr = phase_q ? aleg_pkg::idx_f(nm1, m_q) : aleg_pkg::idx_f(nm1, nm1);
          state_d = S_RD2;
        end
        S_RD2: begin
          cmd_o.re     = 1'b1;
          cmd_o.raddr  = phase_q ? aleg_pkg::idx_f(n_q - 3'd2, m_q) : 6'd0;
          cmd_o.cap_p1 = 1'b1;
          state_d = S_MUL1;
        end
        S_MUL1: begin
          cmd_o.mul_lo = 1'b1;
          state_d = S_MUL2;
        end
        S_MUL2: begin
          cmd_o.mul_hi = 1'b1;
          state_d = S_SCALE;
        end
        S_SCALE: begin
          cmd_o.scale = 1'b1;
          state_d = S_COMB;
        end
        S_COMB: begin
          cmd_o.comb = 1'b1;
          state_d = S_DINIT;
        end
        S_DINIT: begin
          cmd_o.dinit = 1'b1;
          cnt_d   = '0;
          state_d = S_DIV;
        end
        S_DIV: begin
          cmd_o.dstep = 1'b1;
          cnt_d = cnt_q + 3'd1;
          if (32'(cnt_q) == aleg_pkg::DivSteps - 1) state_d = S_WR;
        end
        S_WR: begin
          cmd_o.we = 1'b1;
          state_d  = S_RD1;
          if (!phase_q) begin
            if (!sub_q) begin
              sub_d = 1'b1;
            end else if (n_q != lim_q) begin
              sub_d = 1'b0;
              n_d   = n_q + 3'd1;
            end else if (lim_q >= 3'd2) begin
              phase_d = 1'b1;
              n_d     = 3'd2;
              m_d     = 3'd0;
            end else begin
              state_d = S_ORD;
            end
          end else begin
            if (m_q != n_q - 3'd2) begin
              m_d = m_q + 3'd1;
            end else if (n_q != lim_q) begin
              n_d = n_q + 3'd1;
              m_d = 3'd0;
            end else begin
              state_d = S_ORD;
            end
          end
        end
        S_ORD: begin
          cmd_o.re    = 1'b1;
          cmd_o.raddr = aleg_pkg::idx_f(on_q, om_abs);
          oload_d     = 1'b1;
          state_d     = S_ORD;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oload_q <= 1'b0;
      lim_q   <= '0;
      phase_q <= 1'b0;
      sub_q   <= 1'b0;
      n_q     <= '0;
      m_q     <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      on_q    <= '0;
      om_q    <= '0;
    end else begin
      state_q <= state_d;
      oload_q <= oload_d;
      lim_q   <= lim_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      n_q     <= n_d;
      m_q     <= m_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      on_q    <= on_d;
      om_q    <= om_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE || oload_q;

  a_accept_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_SEED)
    else $error("accepted transfer did not start seeding");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !oload_q && cnt_q == 3'(aleg_pkg::DivSteps - 1)) |=> state_q == S_WR)
    else $error("divider step count wrong");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("output register overwritten");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (state_q == S_IDLE && !oload_q))
    else $error("run did not end after last transfer");

endmodule

/* sv/associated_legendre_table.sv */
// Top level of the associated Legendre table: controller plus datapath.
//
// Input channel: one transfer carries cos_value and sin_value (signed Q1.30) of
// one elevation angle. in_stall_o is high while a run is in progress, so one
// input is processed at a time.
// Output channel: (L+1)^2 transfers per input, L = min(order_in_use, 7), in index
// order n*(n+1)+m with m from -n to n; the final one has last set. Values are
// signed Q18.29, saturated to 48 bits.
// Configuration: cfg_we_i writes order_in_use from cfg_data_i; write only while idle.
// Sequence: each computed entry P_n^m (m >= 0) reads its source entries, then uses
// the shared split multiplier (low, then high half), scaling, combination and the
// 7-step radix-256 divider before its write; there are L(L+3)/2 of them. Each output
// transfer then takes a memory read followed by an output load, one at a time.
// The next input is taken once the last result sits in the output register.
// A stalled receiver holds the output register and freezes the read sequence.
// Reset clears control state and sets order_in_use to 1; the table memory
// needs no clearing since every emitted entry is written first in the run.
module associated_legendre_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  aleg_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output aleg_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_data_i
);

  aleg_pkg::cmd_t    cmd;
  aleg_pkg::status_t status;

  aleg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aleg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
